/* design/assert_macros.svh */
// Assertion macros used by the checker file of the endpoint test command engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/eptce_pkg.sv */
// Types, constants and CRC/xorshift helpers of the endpoint test command engine.
`timescale 1ns / 1ps
package eptce_pkg;

  // Field and bus widths.
  localparam int unsigned SizeW     = 21;
  localparam int unsigned InDataW   = 168;
  localparam int unsigned OutDataW  = 144;

  // Request kinds carried on the input tuser.
  localparam logic [1:0] ReqCommand = 2'd0;
  localparam logic [1:0] ReqData    = 2'd1;
  localparam logic [1:0] ReqPull    = 2'd2;

  // Command bits.
  localparam int unsigned CmdRead  = 3;
  localparam int unsigned CmdWrite = 4;
  localparam int unsigned CmdCopy  = 5;

  // Status bits.
  localparam logic [8:0] StReadOk   = 9'h001;
  localparam logic [8:0] StReadFail = 9'h002;
  localparam logic [8:0] StWriteOk  = 9'h004;
  localparam logic [8:0] StWriteFail= 9'h008;
  localparam logic [8:0] StCopyOk   = 9'h010;
  localparam logic [8:0] StCopyFail = 9'h020;
  localparam logic [8:0] StIrq      = 9'h040;

  // Result kinds.
  localparam logic KindStatus = 1'b0;
  localparam logic KindData   = 1'b1;

  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] CrcInit = 32'hFFFFFFFF;
  localparam logic [31:0] RngSeed = 32'hDEADBEEF;
  localparam logic [SizeW-1:0] MaxXferReset = 21'h100000;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_COPY  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [5:0]  command;
    logic [31:0] xfer_size;
    logic [31:0] expected_crc;
    logic [63:0] target_addr;
    logic [31:0] data_word;
  } item_t;

  typedef struct packed {
    mode_e            mode;
    logic [31:0]      crc_acc;
    logic [SizeW-1:0] bytes_left;
    logic [SizeW-1:0] byte_offset;
    logic [63:0]      dest_base;
    logic [31:0]      crc_target;
    logic [31:0]      rng_state;
  } state_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] addr;
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic [8:0]  status;
    logic [31:0] checksum;
    logic        last;
  } result_t;

  // One queue entry: a result and, where the item finishes a write or copy, the
  // status report that follows it.
  typedef struct packed {
    result_t     first;
    logic        two;
    logic [8:0]  second_status;
    logic [31:0] second_checksum;
  } entry_t;

  // Reflected CRC-32 over one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    logic [7:0]  d;
    c = crc;
    d = data;
    for (int b = 0; b < 8; b++) begin
      if (c[0] ^ d[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    return c;
  endfunction

  // One xorshift32 step, shifts 13, 17 and 5.
  function automatic logic [31:0] rng_step(input logic [31:0] s);
    logic [31:0] x;
    x = s;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

endpackage

/* design/eptce_step.sv */
// Next-state and result logic for one item of the endpoint test command engine.
`timescale 1ns / 1ps
module eptce_step
  import eptce_pkg::*;
(
  input  item_t            item_i,
  input  state_t           cur_i,
  input  logic [SizeW-1:0] max_xfer_i,
  output state_t           nxt_o,
  output entry_t           entry_o,
  output logic             has_result_o
);

  logic [2:0]       nbytes;
  logic [SizeW-1:0] left_new;
  logic [31:0]      rng_new;
  logic [31:0]      src;
  logic [31:0]      word;
  logic [31:0]      crc1, crc2, crc3, crc4, crc_new;
  logic             bad;
  logic             read_go, copy_go, write_go;

  // Bytes covered by this word and the updated count.
  assign nbytes   = (cur_i.bytes_left < SizeW'(4)) ? cur_i.bytes_left[2:0] : 3'd4;
  assign left_new = cur_i.bytes_left - {{(SizeW-3){1'b0}}, nbytes};
  assign rng_new  = rng_step(cur_i.rng_state);
  assign src      = (item_i.req_type == ReqPull) ? rng_new : item_i.data_word;

  // Only the valid low bytes of the final word are kept.
  always_comb begin
    case (nbytes)
      3'd1:    word = {24'd0, src[7:0]};
      3'd2:    word = {16'd0, src[15:0]};
      3'd3:    word = {8'd0, src[23:0]};
      default: word = src;
    endcase
  end

  // CRC over the covered bytes, lowest byte first.
  assign crc1 = crc_byte(cur_i.crc_acc, word[7:0]);
  assign crc2 = crc_byte(crc1, word[15:8]);
  assign crc3 = crc_byte(crc2, word[23:16]);
  assign crc4 = crc_byte(crc3, word[31:24]);

  always_comb begin
    case (nbytes)
      3'd0:    crc_new = cur_i.crc_acc;
      3'd1:    crc_new = crc1;
      3'd2:    crc_new = crc2;
      3'd3:    crc_new = crc3;
      default: crc_new = crc4;
    endcase
  end

  assign bad      = (item_i.xfer_size == 32'd0) ||
                    (item_i.xfer_size > {{(32-SizeW){1'b0}}, max_xfer_i});
  assign read_go  = (item_i.req_type == ReqData) && (cur_i.mode == MODE_READ);
  assign copy_go  = (item_i.req_type == ReqData) && (cur_i.mode == MODE_COPY);
  assign write_go = (item_i.req_type == ReqPull) && (cur_i.mode == MODE_WRITE);

  // Command decode and transfer progress.
  always_comb begin
    nxt_o        = cur_i;
    entry_o      = '0;
    has_result_o = 1'b0;
    if (item_i.req_type == ReqCommand) begin
      nxt_o.mode         = MODE_IDLE;
      entry_o.first.kind = KindStatus;
      entry_o.first.last = 1'b1;
      if (item_i.command[2:0] != 3'd0) begin
        has_result_o         = 1'b1;
        entry_o.first.status = StIrq;
      end else if (bad && (item_i.command[CmdRead] || item_i.command[CmdWrite] ||
                           item_i.command[CmdCopy])) begin
        has_result_o = 1'b1;
        if (item_i.command[CmdRead]) begin
          entry_o.first.status = StReadFail | StIrq;
        end else if (item_i.command[CmdWrite]) begin
          entry_o.first.status = StWriteFail | StIrq;
        end else begin
          entry_o.first.status = StCopyFail | StIrq;
        end
      end else if (item_i.command[CmdRead] || item_i.command[CmdWrite] ||
                   item_i.command[CmdCopy]) begin
        if (item_i.command[CmdRead]) begin
          nxt_o.mode       = MODE_READ;
          nxt_o.crc_target = item_i.expected_crc;
        end else if (item_i.command[CmdWrite]) begin
          nxt_o.mode = MODE_WRITE;
        end else begin
          nxt_o.mode = MODE_COPY;
        end
        nxt_o.bytes_left  = item_i.xfer_size[SizeW-1:0];
        nxt_o.byte_offset = '0;
        nxt_o.dest_base   = item_i.target_addr;
        nxt_o.crc_acc     = CrcInit;
      end else begin
        has_result_o         = 1'b1;
        entry_o.first.status = StIrq;
      end
    end else if (read_go) begin
      nxt_o.crc_acc    = crc_new;
      nxt_o.bytes_left = left_new;
      if (left_new == '0) begin
        nxt_o.mode           = MODE_IDLE;
        has_result_o         = 1'b1;
        entry_o.first.kind   = KindStatus;
        entry_o.first.last   = 1'b1;
        entry_o.first.status = ((crc_new == cur_i.crc_target) ? StReadOk : StReadFail) | StIrq;
      end
    end else if (copy_go || write_go) begin
      if (write_go) begin
        nxt_o.rng_state = rng_new;
        nxt_o.crc_acc   = crc_new;
      end
      nxt_o.bytes_left     = left_new;
      nxt_o.byte_offset    = cur_i.byte_offset + {{(SizeW-3){1'b0}}, nbytes};
      has_result_o         = 1'b1;
      entry_o.first.kind   = KindData;
      entry_o.first.addr   = cur_i.dest_base + {{(64-SizeW){1'b0}}, cur_i.byte_offset};
      entry_o.first.word   = word;
      entry_o.first.nbytes = nbytes;
      entry_o.first.last   = (left_new != '0);
      if (left_new == '0) begin
        nxt_o.mode  = MODE_IDLE;
        entry_o.two = 1'b1;
        if (write_go) begin
          entry_o.second_status   = StWriteOk | StIrq;
          entry_o.second_checksum = crc_new;
        end else begin
          entry_o.second_status   = StCopyOk | StIrq;
        end
      end
    end
  end

endmodule

/* design/endpoint_test_command_engine.sv */
// Top level of the endpoint test command engine: stream ports, state and result queue.
`timescale 1ns / 1ps
// The engine takes one item per clock cycle unless the result queue is full:
// commands, source data words and pull requests for generated write words.
// An accepted item is held in an input register and resolved, once the
// queue has room, by one pass of CRC-32 and xorshift logic against the
// transfer state; its results are registered in a two-entry result queue
// and offered from there. Items that yield no result or one result sustain
// one item per cycle while the master side keeps up; the item that finishes
// a write or copy yields a data result and a status report, which leave as
// two transfers on the master side. The limiting element is the update of
// the CRC accumulator and generator state. The size limit register is
// written through the cfg channel, which is always ready; the user must
// write it only while no item is in flight, as the block does not enforce it.
module endpoint_test_command_engine
  import eptce_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write: max_transfer_bytes.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [SizeW-1:0]     cfg_data_i,
  // Input items.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // command[5:0], xfer_size[37:6], expected_crc[69:38], target_addr[133:70],
  // data_word[165:134], zero fill[167:166].
  input  logic [InDataW-1:0]   s_axis_tdata,
  // req_type[1:0].
  input  logic [1:0]           s_axis_tuser,
  // Results.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // out_addr[63:0], out_word[95:64], out_bytes[98:96], status_word[107:99],
  // checksum_out[139:108], zero fill[143:140].
  output logic [OutDataW-1:0]  m_axis_tdata,
  // result_kind[0].
  output logic [0:0]           m_axis_tuser,
  output logic                 m_axis_tlast
);

  localparam int unsigned QDepth = 2;

  logic             in_valid_q, in_valid_d;
  item_t            in_q;
  state_t           st_q, st_d;
  logic [SizeW-1:0] max_xfer_q;
  entry_t           new_entry;
  logic             has_result;
  entry_t           queue_q [QDepth];
  logic             wr_ptr_q, rd_ptr_q, sel_q;
  logic [1:0]       cnt_q;
  entry_t           head;
  result_t          out_res;
  logic             process, push, pop, pop_entry;

  eptce_step u_step (
    .item_i       (in_q),
    .cur_i        (st_q),
    .max_xfer_i   (max_xfer_q),
    .nxt_o        (st_d),
    .entry_o      (new_entry),
    .has_result_o (has_result)
  );

  // Handshake control.
  assign process       = in_valid_q && (cnt_q != 2'(QDepth));
  assign push          = process && has_result;
  assign s_axis_tready = !in_valid_q || process;
  assign in_valid_d    = s_axis_tready ? s_axis_tvalid : in_valid_q;
  assign cfg_ready_o   = 1'b1;

  assign head          = queue_q[rd_ptr_q];
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign pop_entry     = pop && (sel_q || !head.two);

  // Present the first result of the head entry or its trailing status report.
  always_comb begin
    if (sel_q) begin
      out_res          = '0;
      out_res.kind     = KindStatus;
      out_res.status   = head.second_status;
      out_res.checksum = head.second_checksum;
      out_res.last     = 1'b1;
    end else begin
      out_res = head.first;
    end
  end

  assign m_axis_tdata = {4'd0, out_res.checksum, out_res.status, out_res.nbytes,
                         out_res.word, out_res.addr};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

  // Control state, transfer state and the size limit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q             <= 1'b0;
      st_q.mode              <= MODE_IDLE;
      st_q.crc_acc           <= CrcInit;
      st_q.bytes_left        <= '0;
      st_q.byte_offset       <= '0;
      st_q.dest_base         <= '0;
      st_q.crc_target        <= '0;
      st_q.rng_state         <= RngSeed;
      max_xfer_q             <= MaxXferReset;
      wr_ptr_q               <= 1'b0;
      rd_ptr_q               <= 1'b0;
      sel_q                  <= 1'b0;
      cnt_q                  <= 2'd0;
    end else begin
      in_valid_q <= in_valid_d;
      if (process) begin
        st_q <= st_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        max_xfer_q <= cfg_data_i;
      end
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_entry) begin
        rd_ptr_q <= !rd_ptr_q;
        sel_q    <= 1'b0;
      end else if (pop) begin
        sel_q <= 1'b1;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_entry};
    end
  end

  // Input register and queue payload.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.req_type     <= s_axis_tuser;
      in_q.command      <= s_axis_tdata[5:0];
      in_q.xfer_size    <= s_axis_tdata[37:6];
      in_q.expected_crc <= s_axis_tdata[69:38];
      in_q.target_addr  <= s_axis_tdata[133:70];
      in_q.data_word    <= s_axis_tdata[165:134];
    end
    if (push) begin
      queue_q[wr_ptr_q] <= new_entry;
    end
  end

endmodule

/* design/eptce_checker.sv */
// Port-level checker of the endpoint test command engine and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module eptce_checker
  import eptce_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [0:0]          m_axis_tuser,
  input logic                m_axis_tlast
);

  logic       out_xfer;
  logic       is_status;
  logic       is_data;
  logic       status_shape;
  logic       data_shape;
  logic [2:0] out_nbytes;

  // Result classification and the expected shape of each kind.
  assign out_xfer     = m_axis_tvalid && m_axis_tready;
  assign is_status    = m_axis_tvalid && (m_axis_tuser == KindStatus);
  assign is_data      = m_axis_tvalid && (m_axis_tuser == KindData);
  assign out_nbytes   = m_axis_tdata[98:96];
  assign status_shape = m_axis_tdata[105] && (m_axis_tdata[98:0] == 99'd0) && m_axis_tlast;
  assign data_shape   = (m_axis_tdata[139:99] == 41'd0) && (out_nbytes != 3'd0) &&
                        (out_nbytes <= 3'd4);

  // A stalled result stays offered.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // A status report always carries the irq bit and no data fields.
  `ASSERT_SAME(a_status_form, clk_i, rst_ni, is_status, status_shape)

  // A data result carries one to four bytes and no status.
  `ASSERT_SAME(a_data_form, clk_i, rst_ni, is_data, data_shape)

  // The final data word of a transfer is followed at once by its status report.
  `ASSERT_NEXT(a_report_follows, clk_i, rst_ni, out_xfer && is_data && !m_axis_tlast, is_status)

endmodule

bind endpoint_test_command_engine eptce_checker u_checker (.*);

/* tb/endpoint_test_command_engine_test.sv */
// Self-checking testbench for the endpoint test command engine.
`timescale 1ns / 1ps
module endpoint_test_command_engine_test;
  import eptce_pkg::*;

  // Request kind that the engine must ignore.
  localparam logic [1:0] ReqInvalid = 2'd3;
  // Cycles without any transfer before the run is declared hung.
  localparam int unsigned QuietLimit = 3000;
  // Cycles allowed for an item without results to leave the pipeline.
  localparam int unsigned SettleCycles = 8;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [SizeW-1:0]    cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [1:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [0:0]          m_axis_tuser;
  logic                m_axis_tlast;

  // Items waiting to be sent, and replies the engine still owes.
  item_t       item_backlog[$];
  result_t     owed_replies[$];
  item_t       send_item;
  item_t       seen_item;
  result_t     seen_reply;
  result_t     want_reply;
  int unsigned send_idle_pct = 30;
  int unsigned recv_idle_pct = 49;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  // Mirror of the engine state.
  mode_e            eng_mode;
  logic [31:0]      eng_crc;
  logic [31:0]      eng_crc_goal;
  logic [31:0]      eng_rng;
  logic [SizeW-1:0] eng_left;
  logic [SizeW-1:0] eng_offset;
  logic [63:0]      eng_base;
  logic [SizeW-1:0] transfer_limit;

  endpoint_test_command_engine uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Reflected CRC-32 over the low nbytes of a word, least significant bit first.
  function automatic logic [31:0] crc32_fold(input logic [31:0] crc, input logic [31:0] word,
                                             input logic [2:0] nbytes);
    logic [31:0] c;
    c = crc;
    for (int i = 0; i < 8 * nbytes; i++) begin
      c = (c[0] ^ word[i]) ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] xorshift32(input logic [31:0] s);
    logic [31:0] x;
    x = s ^ (s << 13);
    x = x ^ (x >> 17);
    return x ^ (x << 5);
  endfunction

  function automatic logic [63:0] any64();
    return {$urandom, $urandom};
  endfunction

  function automatic void owe_status(input logic [8:0] status, input logic [31:0] checksum);
    result_t r;
    r = '0;
    r.kind     = KindStatus;
    r.status   = status;
    r.checksum = checksum;
    r.last     = 1'b1;
    owed_replies.push_back(r);
  endfunction

  function automatic void open_job(input mode_e m, input item_t it);
    eng_mode   = m;
    eng_left   = it.xfer_size[SizeW-1:0];
    eng_offset = '0;
    eng_base   = it.target_addr;
    eng_crc    = CrcInit;
  endfunction

  // Advances the mirrored engine by one accepted item and queues the replies it owes.
  function automatic void advance_engine(input item_t it);
    logic [2:0]  n;
    logic [31:0] w;
    logic        size_bad;
    result_t     r;
    n = (eng_left < 4) ? eng_left[2:0] : 3'd4;
    size_bad = (it.xfer_size == 32'd0) || (it.xfer_size > {11'd0, transfer_limit});
    if (it.req_type == ReqCommand) begin
      // A command always drops a running job first; irq bits win over everything.
      eng_mode = MODE_IDLE;
      if (it.command[2:0] != 3'd0) begin
        owe_status(StIrq, 32'd0);
      end else if (it.command[CmdRead]) begin
        if (size_bad) begin
          owe_status(StReadFail | StIrq, 32'd0);
        end else begin
          open_job(MODE_READ, it);
          eng_crc_goal = it.expected_crc;
        end
      end else if (it.command[CmdWrite]) begin
        if (size_bad) owe_status(StWriteFail | StIrq, 32'd0);
        else open_job(MODE_WRITE, it);
      end else if (it.command[CmdCopy]) begin
        if (size_bad) owe_status(StCopyFail | StIrq, 32'd0);
        else open_job(MODE_COPY, it);
      end else begin
        owe_status(StIrq, 32'd0);
      end
    end else if (it.req_type == ReqData && eng_mode == MODE_READ) begin
      // Read: fold the source bytes and report once all have arrived.
      eng_crc  = crc32_fold(eng_crc, it.data_word, n);
      eng_left = eng_left - n;
      if (eng_left == '0) begin
        eng_mode = MODE_IDLE;
        owe_status(((eng_crc == eng_crc_goal) ? StReadOk : StReadFail) | StIrq, 32'd0);
      end
    end else if ((it.req_type == ReqData && eng_mode == MODE_COPY) ||
                 (it.req_type == ReqPull && eng_mode == MODE_WRITE)) begin
      // Write and copy: one data word out, then the status report after the last one.
      if (it.req_type == ReqPull) begin
        eng_rng = xorshift32(eng_rng);
        w = eng_rng;
      end else begin
        w = it.data_word;
      end
      w = w & ~(32'hFFFF_FFFF << (8 * n));
      if (it.req_type == ReqPull) eng_crc = crc32_fold(eng_crc, w, n);
      eng_left = eng_left - n;
      r = '0;
      r.kind   = KindData;
      r.addr   = eng_base + {43'd0, eng_offset};
      r.word   = w;
      r.nbytes = n;
      // The data word is the item's last result only when no report follows it.
      r.last   = (eng_left != '0);
      owed_replies.push_back(r);
      eng_offset = eng_offset + n;
      if (eng_left == '0) begin
        if (eng_mode == MODE_WRITE) owe_status(StWriteOk | StIrq, eng_crc);
        else owe_status(StCopyOk | StIrq, 32'd0);
        eng_mode = MODE_IDLE;
      end
    end
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatch_count++;
    $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic queue_item(input logic [1:0] req, input logic [5:0] cmd,
                            input logic [31:0] size, input logic [31:0] crc,
                            input logic [63:0] dst, input logic [31:0] word);
    item_t it;
    it.req_type     = req;
    it.command      = cmd;
    it.xfer_size    = size;
    it.expected_crc = crc;
    it.target_addr  = dst;
    it.data_word    = word;
    item_backlog.push_back(it);
  endtask

  // Queues one read, write or copy command and the data words or pulls that
  // complete it, or only some of them when the job is to be cut short.
  task automatic queue_job(input int unsigned op, input logic [31:0] size, input logic [63:0] dst,
                           input logic [SizeW-1:0] limit, input bit cut_short,
                           input bit crc_good, output int unsigned queued);
    logic [31:0] words[$];
    logic [31:0] crc;
    logic [5:0]  cmd;
    logic [1:0]  hi;
    logic [1:0]  stray_req;
    logic [2:0]  n;
    int unsigned nwords;
    int unsigned left;
    left   = size;
    crc    = CrcInit;
    nwords = 0;
    hi     = 2'($urandom_range(0, 3));
    if (size != 0 && size <= limit) nwords = (size + 3) / 4;
    if (cut_short && nwords > 1) nwords = $urandom_range(1, (nwords > 8) ? 7 : nwords - 1);
    for (int i = 0; i < nwords; i++) begin
      words.push_back($urandom);
      n    = (left < 4) ? left[2:0] : 3'd4;
      crc  = crc32_fold(crc, words[i], n);
      left = left - n;
    end
    case (op)
      CmdRead:  cmd = {hi, 4'b1000};
      CmdWrite: cmd = {hi[0], 5'b10000};
      default:  cmd = 6'b100000;
    endcase
    queue_item(ReqCommand, cmd, size, crc_good ? crc : $urandom, dst, $urandom);
    for (int i = 0; i < nwords; i++) begin
      // Now and then a stray item that the running job must ignore.
      if ($urandom_range(0, 19) == 0) begin
        stray_req = ($urandom_range(0, 1) != 0) ? ReqInvalid :
                    ((op == CmdWrite) ? ReqData : ReqPull);
        queue_item(stray_req, 6'($urandom), $urandom, $urandom, any64(), $urandom);
      end
      queue_item((op == CmdWrite) ? ReqPull : ReqData, 6'($urandom), $urandom, $urandom,
                 any64(), words[i]);
    end
    queued = nwords + 1;
  endtask

  // Mostly complete jobs with random content; the rest irq commands, bad sizes and noise.
  task automatic queue_random(input int unsigned count, input logic [SizeW-1:0] limit);
    int unsigned made;
    int unsigned pick;
    int unsigned op;
    int unsigned got;
    logic [31:0] size;
    logic [63:0] dst;
    logic [5:0]  cmd;
    bit          cut;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      op   = CmdRead + $urandom_range(0, 2);
      dst  = any64();
      if ($urandom_range(0, 9) == 0) dst[63:8] = '1;
      if (pick < 70) begin
        size = $urandom_range(1, 40);
        cut  = ($urandom_range(0, 6) == 0);
        if (limit <= 64 && $urandom_range(0, 3) == 0) begin
          size = limit;
        end else if (limit > 64 && $urandom_range(0, 49) == 0) begin
          size = $urandom_range(65, limit);
          cut  = 1'b1;
        end
        queue_job(op, size, dst, limit, cut, $urandom_range(0, 9) < 6, got);
        made += got;
      end else if (pick < 85) begin
        cmd      = 6'($urandom);
        cmd[2:0] = 3'($urandom_range(1, 7));
        queue_item(ReqCommand, cmd, $urandom, $urandom, dst, $urandom);
        made++;
      end else if (pick < 93) begin
        case ($urandom_range(0, 2))
          0:       size = 32'd0;
          1:       size = limit + 32'd1;
          default: size = $urandom;
        endcase
        queue_job(op, size, dst, limit, 1'b1, 1'b0, got);
        made += got;
      end else begin
        case ($urandom_range(0, 3))
          0:       queue_item(ReqInvalid, 6'($urandom), $urandom, $urandom, dst, $urandom);
          1:       queue_item(ReqData, 6'($urandom), $urandom, $urandom, dst, $urandom);
          2:       queue_item(ReqPull, 6'($urandom), $urandom, $urandom, dst, $urandom);
          default: begin
            queue_item(ReqCommand, 6'd0, $urandom, $urandom, dst, $urandom);
            made++;
          end
        endcase
      end
    end
  endtask

  // Waits until the backlog has gone out and every owed reply has come back.
  task automatic settle_engine();
    do @(posedge clk_i);
    while (item_backlog.size() != 0 || s_axis_tvalid || owed_replies.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [SizeW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Driver: when the slot is free, presents the next backlog item or, at random, stays idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (item_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        send_item = item_backlog.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, send_item.data_word, send_item.target_addr,
                          send_item.expected_crc, send_item.xfer_size, send_item.command};
        s_axis_tuser  <= send_item.req_type;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transfer, then mirrors register writes and input transfers.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      eng_mode       = MODE_IDLE;
      eng_crc        = CrcInit;
      eng_crc_goal   = '0;
      eng_rng        = RngSeed;
      eng_left       = '0;
      eng_offset     = '0;
      eng_base       = '0;
      transfer_limit = MaxXferReset;
      owed_replies.delete();
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        seen_reply.kind     = m_axis_tuser[0];
        seen_reply.addr     = m_axis_tdata[63:0];
        seen_reply.word     = m_axis_tdata[95:64];
        seen_reply.nbytes   = m_axis_tdata[98:96];
        seen_reply.status   = m_axis_tdata[107:99];
        seen_reply.checksum = m_axis_tdata[139:108];
        seen_reply.last     = m_axis_tlast;
        if (owed_replies.size() == 0) begin
          flag_mismatch("result with none owed, status_word", 64'(seen_reply.status), '0);
        end else begin
          want_reply = owed_replies.pop_front();
          if (seen_reply.kind != want_reply.kind)
            flag_mismatch("result_kind", 64'(seen_reply.kind), 64'(want_reply.kind));
          if (seen_reply.addr != want_reply.addr)
            flag_mismatch("out_addr", seen_reply.addr, want_reply.addr);
          if (seen_reply.word != want_reply.word)
            flag_mismatch("out_word", 64'(seen_reply.word), 64'(want_reply.word));
          if (seen_reply.nbytes != want_reply.nbytes)
            flag_mismatch("out_bytes", 64'(seen_reply.nbytes), 64'(want_reply.nbytes));
          if (seen_reply.status != want_reply.status)
            flag_mismatch("status_word", 64'(seen_reply.status), 64'(want_reply.status));
          if (seen_reply.checksum != want_reply.checksum)
            flag_mismatch("checksum_out", 64'(seen_reply.checksum),
                          64'(want_reply.checksum));
          if (seen_reply.last != want_reply.last)
            flag_mismatch("last", 64'(seen_reply.last), 64'(want_reply.last));
        end
      end
      if (cfg_valid_i && cfg_ready_o) transfer_limit = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        seen_item.req_type     = s_axis_tuser;
        seen_item.command      = s_axis_tdata[5:0];
        seen_item.xfer_size    = s_axis_tdata[37:6];
        seen_item.expected_crc = s_axis_tdata[69:38];
        seen_item.target_addr  = s_axis_tdata[133:70];
        seen_item.data_word    = s_axis_tdata[165:134];
        advance_engine(seen_item);
      end
    end
  end

  // Watchdog: ends the run if no transfer of any kind happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("No transfer for %0d cycles, %0d replies still owed", QuietLimit,
               owed_replies.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus: directed cases, then random phases under several size limits.
  initial begin
    logic [SizeW-1:0] limit_now;
    int unsigned      got;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Stray items while idle, then irq and unknown commands.
    queue_item(ReqData, 6'($urandom), $urandom, $urandom, any64(), $urandom);
    queue_item(ReqPull, 6'($urandom), $urandom, $urandom, any64(), $urandom);
    queue_item(ReqInvalid, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, 32'hFFFF_FFFF);
    queue_item(ReqCommand, 6'h00, 32'd4, $urandom, any64(), $urandom);
    queue_item(ReqCommand, 6'h3F, 32'd4, $urandom, any64(), $urandom);
    queue_item(ReqCommand, 6'h01, 32'd0, $urandom, any64(), $urandom);
    // Size zero and sizes above the limit fail each operation at once.
    queue_job(CmdRead, 32'd0, any64(), MaxXferReset, 1'b0, 1'b0, got);
    queue_job(CmdWrite, 32'h0010_0001, any64(), MaxXferReset, 1'b0, 1'b0, got);
    queue_job(CmdCopy, 32'hFFFF_FFFF, '0, MaxXferReset, 1'b0, 1'b0, got);
    // Reads with a good and a wrong checksum, then a write; the first and last end short.
    queue_job(CmdRead, 32'd5, any64(), MaxXferReset, 1'b0, 1'b1, got);
    queue_job(CmdRead, 32'd4, any64(), MaxXferReset, 1'b0, 1'b0, got);
    queue_job(CmdWrite, 32'd6, any64(), MaxXferReset, 1'b0, 1'b0, got);
    // Copy whose destination address wraps past the top of the address space.
    queue_job(CmdCopy, 32'd8, 64'hFFFF_FFFF_FFFF_FFFC, MaxXferReset, 1'b0, 1'b0, got);
    // A write dropped by a new command with every operation bit set.
    queue_job(CmdWrite, 32'd12, any64(), MaxXferReset, 1'b1, 1'b0, got);
    queue_item(ReqCommand, 6'h38, 32'd2, $urandom, any64(), $urandom);
    queue_item(ReqData, 6'($urandom), $urandom, $urandom, any64(), $urandom);
    settle_engine();

    // Smallest limits: one byte, then nothing accepted at all.
    write_limit(21'd1);
    queue_random(60, 21'd1);
    settle_engine();
    write_limit(21'd0);
    queue_random(20, 21'd0);
    settle_engine();

    // Largest limit, starting with a job of the full size that is cut short.
    write_limit(21'h1F_FFFF);
    queue_job(CmdCopy, 32'h001F_FFFF, any64(), 21'h1F_FFFF, 1'b1, 1'b0, got);
    queue_random(600, 21'h1F_FFFF);
    settle_engine();

    send_idle_pct <= 49;
    recv_idle_pct <= 30;
    limit_now = SizeW'($urandom_range(16, 200));
    write_limit(limit_now);
    queue_random(600, limit_now);
    settle_engine();

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    write_limit(MaxXferReset);
    queue_random(550, MaxXferReset);
    settle_engine();

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
